>>> src/kvs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the key velocity sensor.
// Used by the divider and the top level; depends on nothing.
package kvs_pkg;

    localparam int SAMPLE_W = 12;
    localparam int TICK_W   = 32;
    localparam int KEY_W    = 3;
    localparam int VEL_W    = 7;
    localparam int SPEED_W  = 16;
    localparam int PROD_W   = SPEED_W + VEL_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_CNT_W  = 5;

    localparam logic [VEL_W-1:0] VEL_MAX = 7'd127;
    localparam logic [VEL_W-1:0] PRES_MAX = 7'd127;

    localparam logic [SAMPLE_W-1:0] RST_UPPER     = 12'd3800;
    localparam logic [SAMPLE_W-1:0] RST_LOWER     = 12'd3600;
    localparam logic [KEY_W-1:0]    RST_ALT_KEY   = 3'd1;
    localparam logic [SAMPLE_W-1:0] RST_ALT_UPPER = 12'd1000;
    localparam logic [SAMPLE_W-1:0] RST_ALT_LOWER = 12'd850;
    localparam logic [SPEED_W-1:0]  RST_FULL_SCALE = 16'd200;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UPPER      = 3'd0,
        CFG_LOWER      = 3'd1,
        CFG_ALT_KEY    = 3'd2,
        CFG_ALT_UPPER  = 3'd3,
        CFG_ALT_LOWER  = 3'd4,
        CFG_FULL_SCALE = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_NOTE_ON  = 2'd1,
        EV_NOTE_OFF = 2'd2,
        EV_CLEAR    = 2'd3
    } t_event;

    typedef struct packed {
        logic                 start;
        logic [SPEED_W-1:0]   rem;
        logic [SPEED_W-1:0]   bits;
        logic [DIV_CNT_W-1:0] steps;
        logic [SPEED_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [SPEED_W-1:0] quo;
    } t_div_resp;

endpackage

>>> src/kvs_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package needed.
module kvs_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/kvs_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, with a preset remainder.
// Depends on kvs_pkg for the request and response structs.
module kvs_div
    import kvs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_req  i_req,
    output t_div_resp o_resp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [SPEED_W-1:0]   r_rem;
    logic [SPEED_W-1:0]   r_bits;
    logic [SPEED_W-1:0]   r_quo;
    logic [SPEED_W-1:0]   r_div;

    logic [SPEED_W:0]     trial;
    logic                 fits;
    logic [SPEED_W:0]     diff;

    always_comb begin
        trial = {r_rem, r_bits[SPEED_W-1]};
        fits  = (trial >= {1'b0, r_div});
        diff  = trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.rem;
            r_bits <= i_req.bits;
            r_div  <= i_req.divisor;
            r_quo  <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? diff[SPEED_W-1:0] : trial[SPEED_W-1:0];
            r_bits <= {r_bits[SPEED_W-2:0], 1'b0};
            r_quo  <= {r_quo[SPEED_W-2:0], fits};
        end
    end

    assign o_resp.done = r_done;
    assign o_resp.quo  = r_quo;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider finished without running");

    a_busy_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_req.start) |=> (r_busy || r_done))
        else $error("divider stopped without finishing");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> (r_rem < r_div))
        else $error("divider remainder out of range");

endmodule

>>> src/key_velocity_sensor_core.sv
`timescale 1ns / 1ps
// Key velocity sensor: per-key pressure pad qualifier with two-threshold timing.
// Depends on kvs_pkg, kvs_ram and kvs_div.
//
// One request is handled at a time. A clear-all request, or a sample for a key at or above
// NUM_KEYS, goes straight to the result. An ordinary sample passes through the key state update
// first. A note-on whose velocity is timed also waits on the shared bit-serial divider, first
// for speed and then for scaling. Key state sits in a RAM with registered read data and a
// valid bit per key, so a clear-all takes effect at once. A finished result waits in the output
// register while the next request is accepted.
module key_velocity_sensor_core
    import kvs_pkg::*;
#(
    parameter int NUM_KEYS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // tdata: key[2:0], sample[14:3], now[46:15], zero pad[47]
    input  logic [47:0]           i_s_axis_tdata,
    // tuser: action[0]
    input  logic                  i_s_axis_tuser,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata: event_key[2:0], velocity[9:3], held[10], pressure[17:11], zero pad[23:18]
    output logic [23:0]           o_m_axis_tdata,
    // tuser: event_res[1:0]
    output logic [1:0]            o_m_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW     = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int ENT_W  = 1 + TICK_W;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CALC = 7'b0000010,
        S_DIV1 = 7'b0000100,
        S_CHK  = 7'b0001000,
        S_DIV2 = 7'b0010000,
        S_DONE = 7'b0100000,
        S_HOLD = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [SAMPLE_W-1:0] r_upper, r_lower, r_alt_upper, r_alt_lower;
    logic [KEY_W-1:0]    r_alt_key;
    logic [SPEED_W-1:0]  r_full_scale;

    logic [NUM_KEYS-1:0] r_valid;
    logic [KEY_W-1:0]    r_key;
    logic [AW-1:0]       r_addr;
    logic [SAMPLE_W-1:0] r_smp;
    logic [TICK_W-1:0]   r_now;

    t_event              r_ev;
    logic [VEL_W-1:0]    r_vel;
    logic                r_held;
    logic [VEL_W-1:0]    r_pres;
    logic [PROD_W-1:0]   r_prod;

    logic                r_out_valid;
    logic [23:0]         r_out_data;
    t_event              r_out_user;

    logic                in_acc;
    logic                in_action;
    logic [KEY_W-1:0]    in_key;
    logic                in_range;

    logic [ENT_W-1:0]    rd_data;
    logic                cur_p;
    logic [TICK_W-1:0]   cur_s;
    logic                alt;
    logic [SAMPLE_W-1:0] up, lo;
    logic                below_lo, below_up;
    logic                do_on, do_start, do_off;
    logic                new_p;
    logic [TICK_W-1:0]   new_s;
    logic [SAMPLE_W-1:0] diff12;
    logic [15:0]         elapsed;
    logic [VEL_W-1:0]    pres_val;
    logic                mem_we;

    t_div_req            div_req;
    t_div_resp           div_resp;

    assign in_action = i_s_axis_tuser;
    assign in_key    = i_s_axis_tdata[2:0];
    assign in_range  = ({4'd0, in_key} < 7'(NUM_KEYS));
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper      <= RST_UPPER;
            r_lower      <= RST_LOWER;
            r_alt_key    <= RST_ALT_KEY;
            r_alt_upper  <= RST_ALT_UPPER;
            r_alt_lower  <= RST_ALT_LOWER;
            r_full_scale <= RST_FULL_SCALE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_UPPER:      r_upper      <= i_cfg_data[SAMPLE_W-1:0];
                CFG_LOWER:      r_lower      <= i_cfg_data[SAMPLE_W-1:0];
                CFG_ALT_KEY:    r_alt_key    <= i_cfg_data[KEY_W-1:0];
                CFG_ALT_UPPER:  r_alt_upper  <= i_cfg_data[SAMPLE_W-1:0];
                CFG_ALT_LOWER:  r_alt_lower  <= i_cfg_data[SAMPLE_W-1:0];
                CFG_FULL_SCALE: r_full_scale <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    kvs_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_KEYS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_addr),
        .i_wdata ({new_p, new_s}),
        .i_re    (in_acc),
        .i_raddr (AW'(in_key)),
        .o_rdata (rd_data)
    );

    kvs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_resp  (div_resp)
    );

    always_comb begin
        cur_p    = r_valid[r_addr] ? rd_data[ENT_W-1] : 1'b0;
        cur_s    = r_valid[r_addr] ? rd_data[TICK_W-1:0] : '0;
        alt      = (r_key == r_alt_key);
        up       = alt ? r_alt_upper : r_upper;
        lo       = alt ? r_alt_lower : r_lower;
        below_lo = (r_smp < lo);
        below_up = (r_smp < up);
        do_on    = below_lo && !cur_p;
        do_start = !do_on && below_up && (cur_s == '0) && !cur_p;
        do_off   = !do_on && !do_start && !below_up && cur_p;
        new_p    = do_on ? 1'b1 : (do_off ? 1'b0 : cur_p);
        new_s    = do_start ? r_now : (do_off ? '0 : cur_s);
        diff12   = up - r_smp;
        elapsed  = r_now[15:0] - cur_s[15:0];
        pres_val = diff12[11] ? PRES_MAX : diff12[10:4];
        mem_we   = (r_state == S_CALC);
    end

    always_comb begin
        div_req = '0;
        if (r_state == S_CALC && do_on && !(cur_s == '0 || elapsed == '0 || alt)) begin
            div_req.start   = 1'b1;
            div_req.rem     = '0;
            div_req.bits    = {diff12, 4'd0};
            div_req.steps   = DIV_CNT_W'(SPEED_W);
            div_req.divisor = elapsed;
        end else if (r_state == S_CHK && r_full_scale != '0
                     && r_prod < {r_full_scale, 7'd0}) begin
            div_req.start   = 1'b1;
            div_req.rem     = r_prod[PROD_W-1:VEL_W];
            div_req.bits    = {r_prod[VEL_W-1:0], 9'd0};
            div_req.steps   = DIV_CNT_W'(VEL_W);
            div_req.divisor = r_full_scale;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (in_action || !in_range) ? S_DONE : S_CALC;
                end
            end
            S_CALC: n_state = div_req.start ? S_DIV1 : S_DONE;
            S_DIV1: n_state = div_resp.done ? S_CHK : S_DIV1;
            S_CHK:  n_state = div_req.start ? S_DIV2 : S_DONE;
            S_DIV2: n_state = div_resp.done ? S_DONE : S_DIV2;
            S_DONE: n_state = (!r_out_valid || i_m_axis_tready) ? S_IDLE : S_HOLD;
            S_HOLD: n_state = (!r_out_valid || i_m_axis_tready) ? S_IDLE : S_HOLD;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc && in_action) begin
                r_valid <= '0;
            end else if (mem_we) begin
                r_valid[r_addr] <= 1'b1;
            end
            if ((r_state == S_DONE || r_state == S_HOLD) && n_state == S_IDLE) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_key  <= in_action ? '0 : in_key;
            r_addr <= AW'(in_key);
            r_smp  <= i_s_axis_tdata[14:3];
            r_now  <= i_s_axis_tdata[46:15];
            r_ev   <= in_action ? EV_CLEAR : EV_NONE;
            r_vel  <= '0;
            r_held <= 1'b0;
            r_pres <= '0;
        end
        if (r_state == S_CALC) begin
            r_ev   <= do_on ? EV_NOTE_ON : (do_off ? EV_NOTE_OFF : EV_NONE);
            r_held <= new_p;
            r_pres <= (new_p && below_up) ? pres_val : '0;
            r_vel  <= do_on ? VEL_MAX : '0;
        end
        if (r_state == S_DIV1 && div_resp.done) begin
            r_prod <= {div_resp.quo, 7'd0} - PROD_W'(div_resp.quo);
        end
        if (r_state == S_CHK && !div_req.start) begin
            r_vel <= (r_full_scale == '0) ? '0 : VEL_MAX;
        end
        if (r_state == S_DIV2 && div_resp.done) begin
            r_vel <= div_resp.quo[VEL_W-1:0];
        end
        if ((r_state == S_DONE || r_state == S_HOLD) && n_state == S_IDLE) begin
            r_out_data <= {6'd0, r_pres, r_held, r_vel, r_key};
            r_out_user <= r_ev;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_action) |=> (r_valid == '0))
        else $error("clear request left a key marked valid");

    a_clear_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == EV_CLEAR) |-> (o_m_axis_tdata == '0))
        else $error("clear result carries data");

    a_pressure_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[10]) |-> (o_m_axis_tdata[17:11] == '0))
        else $error("pressure reported for a released key");

    a_on_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == EV_NOTE_ON) |-> o_m_axis_tdata[10])
        else $error("note on without the key held");

    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_resp.done |-> (r_state == S_DIV1 || r_state == S_DIV2))
        else $error("divider result outside a divide state");

endmodule
